[sv/bbcb_pkg.sv]
// ----------------------------------------------------------------------------
// bbcb_pkg: shared types and codes for the basic block builder
// Entry and cell-control structs, instruction kinds, record and edge codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcb_pkg;

	localparam int unsigned ADDR_W = 64;
	localparam int unsigned IW     = 6;   // index/count width, covers up to 63 entries

	typedef enum logic [1:0] {
		KIND_OTHER = 2'd0,
		KIND_JMP   = 2'd1,
		KIND_CJMP  = 2'd2,
		KIND_RET   = 2'd3
	} ikind_t;

	typedef enum logic [2:0] {
		REC_BLOCK = 3'd0,
		REC_OK    = 3'd1,
		REC_DUP   = 3'd2,
		REC_NOIMM = 3'd3,
		REC_OVF   = 3'd4
	} rec_t;

	typedef enum logic [1:0] {
		EDGE_NONE  = 2'd0,
		EDGE_RES   = 2'd1,
		EDGE_UNRES = 2'd2
	} edge_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [3:0]        len;
		logic [1:0]        kind;
		logic [ADDR_W-1:0] target;
		logic              leader;
		logic [IW-1:0]     owner;
	} entry_t;

	typedef struct packed {
		logic              ld_en;
		logic [IW-1:0]     ld_idx;
		logic [ADDR_W-1:0] ld_addr;
		logic [3:0]        ld_len;
		logic [1:0]        ld_kind;
		logic [ADDR_W-1:0] ld_target;
		logic              lead_clr;
		logic              lead_hit_en;
		logic              lead_idx_en;
		logic [IW-1:0]     lead_idx;
		logic              own_en;
		logic [IW-1:0]     own_idx;
		logic [IW-1:0]     own_val;
		logic [ADDR_W-1:0] query;
		logic [IW-1:0]     count;
	} cell_ctl_t;

endpackage

`default_nettype wire

[sv/basic_block_cfg_builder.sv]
// ----------------------------------------------------------------------------
// basic_block_cfg_builder: basic block partition and reachability
// Loads decoded instructions, splits them into basic blocks, resolves edges
// and marks the blocks reachable from block 0.
// ----------------------------------------------------------------------------
// Usage:
//  Slave stream s_*: one decoded instruction per word, one word per cycle
//  while loading. s_tlast marks the final instruction and starts the build;
//  s_tready stays low until the run's status word has been loaded.
//  Master stream m_*: one block record per block, then one status word with
//  m_tlast high. On an error only the status word is sent.
//  Build steps for n instructions and nb blocks: the duplicate scan
//  (one search of the cell row per pass), the leader pass, the partition,
//  the edge pass and one reachability pass over the blocks per block, then
//  the records. Each search is a combinational compare in every cell
//  plus a first-hit token rippled along the row.
//  Reset clears the count, the error flags and the output valid flag.
//  A stalled receiver holds the current word; the next word waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module basic_block_cfg_builder #(
	parameter int unsigned MAX_INSTRUCTIONS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [103:0] s_tdata,  // instruction_address, instruction_length,
	                                    // has_immediate_target, branch_displacement
	input  wire logic [1:0]   s_tuser,  // instruction_kind
	input  wire logic         s_tlast,  // last_instruction
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [223:0]      m_tdata,  // block_address, first_index, end_index,
	                                    // reachable, branch_edge, branch_address,
	                                    // branch_block, fallthrough_edge,
	                                    // fallthrough_address, fallthrough_block
	output logic [2:0]        m_tuser,  // record_kind
	output logic              m_tlast   // last_result
);
	import bbcb_pkg::*;

	localparam int unsigned N  = MAX_INSTRUCTIONS;
	localparam int unsigned XW = $clog2(N);
	localparam logic [IW-1:0] MAXC = IW'(N);

	typedef enum logic [3:0] {
		ST_LOAD, ST_CHK, ST_DUP, ST_LEAD, ST_PART, ST_EDGE, ST_REACH, ST_EMIT, ST_STAT
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     n_q, i_q, nb_q, b_q, it_q;
	logic [1:0]        sub_q;
	logic              noimm_q, ovf_q;
	logic [2:0]        code_q;
	logic [ADDR_W-1:0] query_q;

	logic [IW-1:0]     bfirst_q [N];
	logic [IW-1:0]     bend_q   [N];
	logic [1:0]        brk_q    [N];
	logic [ADDR_W-1:0] bra_q    [N];
	logic [IW-1:0]     brb_q    [N];
	logic [1:0]        ftk_q    [N];
	logic [ADDR_W-1:0] fta_q    [N];
	logic [IW-1:0]     ftb_q    [N];
	logic [N-1:0]      reach_q;

	logic              out_valid_q, out_last_q;
	logic [2:0]        out_kind_q;
	logic [ADDR_W-1:0] out_baddr_q, out_braddr_q, out_ftaddr_q;
	logic [4:0]        out_first_q, out_brb_q, out_ftb_q;
	logic [5:0]        out_end_q;
	logic              out_reach_q;
	logic [1:0]        out_brk_q, out_ftk_q;

	cell_ctl_t ctl;
	entry_t    ent [N];
	logic [N:0]   hit;
	logic [N-1:0] match, first;

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			bbcb_cell #(.INDEX(g)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.hit_in (hit[g]),
				.hit_out(hit[g+1]),
				.match  (match[g]),
				.first  (first[g]),
				.ent    (ent[g])
			);
		end
	endgenerate
	assign hit[0] = 1'b0;

	logic              found, other_hit, s_acc, out_free, is_jump, has_ft, lead;
	logic [IW-1:0]     hit_owner, last_idx, rd_idx, nb_next;
	logic [N-1:0]      self_mask, reach_add;
	entry_t            re;
	logic [ADDR_W-1:0] in_target, re_next;
	logic [XW-1:0]     b_ix, nb_ix, nbp_ix, nbn_ix, rd_ix, bf_ix, brb_ix, ftb_ix;

	assign b_ix   = b_q[XW-1:0];
	assign nb_ix  = nb_q[XW-1:0];
	assign nbp_ix = XW'(nb_q - IW'(1));
	assign nbn_ix = XW'(nb_next - IW'(1));
	assign rd_ix  = rd_idx[XW-1:0];
	assign bf_ix  = bfirst_q[b_ix][XW-1:0];
	assign brb_ix = brb_q[b_ix][XW-1:0];
	assign ftb_ix = ftb_q[b_ix][XW-1:0];

	always_comb begin
		hit_owner = '0;
		self_mask = '0;
		for (int k = 0; k < N; k++) begin
			if (first[k]) hit_owner = hit_owner | ent[k].owner;
			if (i_q == IW'(k)) self_mask[k] = 1'b1;
		end
	end

	always_comb begin
		reach_add = '0;
		if (brk_q[b_ix] == EDGE_RES) reach_add[brb_ix] = 1'b1;
		if (ftk_q[b_ix] == EDGE_RES) reach_add[ftb_ix] = 1'b1;
	end

	assign found     = hit[N];
	assign other_hit = |(match & ~self_mask);
	assign s_acc     = s_tvalid & s_tready;
	assign s_tready  = (state_q == ST_LOAD);
	assign out_free  = ~out_valid_q | m_tready;
	assign last_idx  = bend_q[b_ix] - IW'(1);
	assign rd_idx    = (state_q == ST_EDGE) ? last_idx : i_q;
	assign re        = ent[rd_ix];
	assign is_jump   = (re.kind == KIND_JMP) || (re.kind == KIND_CJMP);
	assign has_ft    = (re.kind == KIND_OTHER) || (re.kind == KIND_CJMP);
	assign re_next   = re.addr + ADDR_W'(re.len);
	assign lead      = re.leader;
	assign nb_next   = lead ? nb_q + IW'(1) : nb_q;
	assign in_target = s_tdata[63:0] + ADDR_W'(s_tdata[67:64])
	                 + {{32{s_tdata[100]}}, s_tdata[100:69]};

	always_comb begin
		ctl.ld_en       = s_acc && (n_q < MAXC);
		ctl.ld_idx      = n_q;
		ctl.ld_addr     = s_tdata[63:0];
		ctl.ld_len      = s_tdata[67:64];
		ctl.ld_kind     = s_tuser;
		ctl.ld_target   = in_target;
		ctl.lead_clr    = (state_q == ST_CHK);
		ctl.lead_hit_en = (state_q == ST_LEAD) && sub_q[0] && is_jump;
		ctl.lead_idx_en = (state_q == ST_LEAD) && sub_q[0] && (re.kind != KIND_OTHER)
		                && (i_q + IW'(1) < n_q);
		ctl.lead_idx    = i_q + IW'(1);
		ctl.own_en      = (state_q == ST_PART);
		ctl.own_idx     = i_q;
		ctl.own_val     = nb_next - IW'(1);
		ctl.query       = query_q;
		ctl.count       = n_q;
	end

	// block table
	always_ff @(posedge clk) begin
		if (state_q == ST_PART) begin
			if (lead) begin
				if (nb_q != '0) bend_q[nbp_ix] <= i_q;
				bfirst_q[nb_ix] <= i_q;
			end
			if (i_q == n_q - IW'(1)) bend_q[nbn_ix] <= n_q;
		end
		if (state_q == ST_EDGE && sub_q == 2'd1) begin
			brk_q[b_ix] <= is_jump ? (found ? EDGE_RES : EDGE_UNRES) : EDGE_NONE;
			bra_q[b_ix] <= is_jump ? re.target : '0;
			brb_q[b_ix] <= (is_jump && found) ? hit_owner : '0;
		end
		if (state_q == ST_EDGE && sub_q == 2'd3) begin
			ftk_q[b_ix] <= has_ft ? (found ? EDGE_RES : EDGE_UNRES) : EDGE_NONE;
			fta_q[b_ix] <= has_ft ? re_next : '0;
			ftb_q[b_ix] <= (has_ft && found) ? hit_owner : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= '0;
		end else if (state_q == ST_EDGE && sub_q == 2'd3 && b_q == nb_q - IW'(1)) begin
			reach_q <= N'(1);
		end else if (state_q == ST_REACH && reach_q[b_ix]) begin
			reach_q <= reach_q | reach_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			n_q         <= '0;
			i_q         <= '0;
			nb_q        <= '0;
			b_q         <= '0;
			it_q        <= '0;
			sub_q       <= '0;
			noimm_q     <= 1'b0;
			ovf_q       <= 1'b0;
			code_q      <= REC_OK;
			query_q     <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_kind_q  <= REC_BLOCK;
		end else begin
			if (m_tready && state_q != ST_EMIT && state_q != ST_STAT) out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (n_q < MAXC) begin
							n_q <= n_q + IW'(1);
							if ((s_tuser == KIND_JMP || s_tuser == KIND_CJMP) && !s_tdata[68])
								noimm_q <= 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_tlast) state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					i_q   <= '0;
					sub_q <= '0;
					if (ovf_q) begin
						code_q  <= REC_OVF;
						state_q <= ST_STAT;
					end else begin
						state_q <= ST_DUP;
					end
				end
				ST_DUP: begin
					if (sub_q == 2'd0) begin
						query_q <= re.addr;
						sub_q   <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						if (other_hit) begin
							code_q  <= REC_DUP;
							state_q <= ST_STAT;
						end else if (i_q == n_q - IW'(1)) begin
							i_q <= '0;
							if (noimm_q) begin
								code_q  <= REC_NOIMM;
								state_q <= ST_STAT;
							end else begin
								state_q <= ST_LEAD;
							end
						end else begin
							i_q <= i_q + IW'(1);
						end
					end
				end
				ST_LEAD: begin
					if (sub_q == 2'd0) begin
						query_q <= re.target;
						sub_q   <= 2'd1;
					end else begin
						sub_q <= 2'd0;
						if (i_q == n_q - IW'(1)) begin
							i_q     <= '0;
							nb_q    <= '0;
							state_q <= ST_PART;
						end else begin
							i_q <= i_q + IW'(1);
						end
					end
				end
				ST_PART: begin
					nb_q <= nb_next;
					if (i_q == n_q - IW'(1)) begin
						b_q     <= '0;
						sub_q   <= '0;
						state_q <= ST_EDGE;
					end else begin
						i_q <= i_q + IW'(1);
					end
				end
				ST_EDGE: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd0) query_q <= re.target;
					if (sub_q == 2'd2) query_q <= re_next;
					if (sub_q == 2'd3) begin
						if (b_q == nb_q - IW'(1)) begin
							b_q     <= '0;
							it_q    <= '0;
							state_q <= ST_REACH;
						end else begin
							b_q <= b_q + IW'(1);
						end
					end
				end
				ST_REACH: begin
					if (b_q == nb_q - IW'(1)) begin
						b_q <= '0;
						if (it_q == nb_q - IW'(1)) state_q <= ST_EMIT;
						else it_q <= it_q + IW'(1);
					end else begin
						b_q <= b_q + IW'(1);
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b0;
						out_kind_q   <= REC_BLOCK;
						out_baddr_q  <= ent[bf_ix].addr;
						out_first_q  <= bfirst_q[b_ix][4:0];
						out_end_q    <= bend_q[b_ix];
						out_reach_q  <= reach_q[b_ix];
						out_brk_q    <= brk_q[b_ix];
						out_braddr_q <= bra_q[b_ix];
						out_brb_q    <= brb_q[b_ix][4:0];
						out_ftk_q    <= ftk_q[b_ix];
						out_ftaddr_q <= fta_q[b_ix];
						out_ftb_q    <= ftb_q[b_ix][4:0];
						if (b_q == nb_q - IW'(1)) begin
							code_q  <= REC_OK;
							state_q <= ST_STAT;
						end else begin
							b_q <= b_q + IW'(1);
						end
					end
				end
				ST_STAT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_last_q   <= 1'b1;
						out_kind_q   <= code_q;
						out_baddr_q  <= '0;
						out_first_q  <= '0;
						out_end_q    <= '0;
						out_reach_q  <= 1'b0;
						out_brk_q    <= EDGE_NONE;
						out_braddr_q <= '0;
						out_brb_q    <= '0;
						out_ftk_q    <= EDGE_NONE;
						out_ftaddr_q <= '0;
						out_ftb_q    <= '0;
						n_q          <= '0;
						noimm_q      <= 1'b0;
						ovf_q        <= 1'b0;
						state_q      <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {6'd0, out_ftb_q, out_ftaddr_q, out_ftk_q, out_brb_q, out_braddr_q,
	                   out_brk_q, out_reach_q, out_end_q, out_first_q, out_baddr_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAXC)
		else $error("instruction count beyond capacity");

	a_first_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first))
		else $error("more than one first hit in the cell row");

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser != REC_BLOCK)
		else $error("final word is a block record");

	a_emit_has_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> nb_q != '0)
		else $error("emitting with no blocks");

	a_no_load_while_build: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_LOAD |-> !ctl.ld_en)
		else $error("cell write outside loading");

endmodule

`default_nettype wire

[sv/bbcb_cell.sv]
// ----------------------------------------------------------------------------
// bbcb_cell: one instruction slot of the builder row
// Holds one entry, compares it against the search address and passes the
// first-hit token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcb_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bbcb_pkg::cell_ctl_t ctl,
	input  wire logic              hit_in,
	output logic                   hit_out,
	output logic                   match,
	output logic                   first,
	output bbcb_pkg::entry_t       ent
);
	import bbcb_pkg::*;

	localparam logic [IW-1:0] MY = IW'(INDEX);

	logic [ADDR_W-1:0] addr_q;
	logic [3:0]        len_q;
	logic [1:0]        kind_q;
	logic [ADDR_W-1:0] target_q;
	logic [IW-1:0]     owner_q;
	logic              leader_q;

	always_ff @(posedge clk) begin
		if (ctl.ld_en && ctl.ld_idx == MY) begin
			addr_q   <= ctl.ld_addr;
			len_q    <= ctl.ld_len;
			kind_q   <= ctl.ld_kind;
			target_q <= ctl.ld_target;
		end
		if (ctl.own_en && ctl.own_idx == MY) begin
			owner_q <= ctl.own_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_q <= 1'b0;
		end else if (ctl.lead_clr) begin
			leader_q <= 1'b0;
		end else if ((ctl.lead_hit_en && first) || (ctl.lead_idx_en && ctl.lead_idx == MY)) begin
			leader_q <= 1'b1;
		end
	end

	assign match   = (MY < ctl.count) && (addr_q == ctl.query);
	assign first   = match & ~hit_in;
	assign hit_out = hit_in | match;

	always_comb begin
		ent.addr   = addr_q;
		ent.len    = len_q;
		ent.kind   = kind_q;
		ent.target = target_q;
		ent.leader = leader_q | (INDEX == 0);
		ent.owner  = owner_q;
	end

endmodule

`default_nettype wire

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: basic block builder testbench
// Streams instruction lists into the builder and checks every block record
// and status word against a behavioral model of the partition, edge
// resolution and reachability. Random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import bbcb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXN  = 32;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [63:0] addr;
		logic [3:0]  len;
		ikind_t      kind;
		logic        imm;
		logic [31:0] disp;
		logic        last;
		logic        drain;
	} instr_t;

	typedef struct {
		rec_t        kind;
		logic [63:0] baddr;
		logic [4:0]  first;
		logic [5:0]  endi;
		logic        reach;
		edge_t       be;
		logic [63:0] ba;
		logic [4:0]  bb;
		edge_t       fe;
		logic [63:0] fa;
		logic [4:0]  fb;
		logic        last;
	} record_t;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready, s_tlast;
	logic [103:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready, m_tlast;
	logic [223:0] m_tdata;
	logic [2:0]   m_tuser;

	basic_block_cfg_builder uut (.*);

	instr_t  pending[$];
	record_t expected_records[$];
	instr_t  cur;
	int      errors = 0;
	int      cycle = 0;
	int      tx_gap = 0, rx_gap = 0, rx_hold = 0;
	logic    calm = 0;

	// model state
	logic [63:0] m_addr[MAXN];
	logic [3:0]  m_len[MAXN];
	ikind_t      m_kind[MAXN];
	logic [63:0] m_tgt[MAXN];
	int          m_count = 0;
	logic        m_noimm = 0, m_ovf = 0;

	function automatic int find_addr(logic [63:0] a);
		for (int j = 0; j < m_count; j++)
			if (m_addr[j] == a) return j;
		return -1;
	endfunction

	function automatic record_t status_rec(rec_t k);
		record_t r;
		r = '{kind: k, be: EDGE_NONE, fe: EDGE_NONE, last: 1'b1, default: '0};
		return r;
	endfunction

	task automatic add_rec(record_t r);
		expected_records.insert(expected_records.size(), r);
	endtask

	task automatic build_blocks();
		logic    leader[MAXN];
		int      owner[MAXN], bfirst[MAXN], bend[MAXN];
		logic    reach[MAXN];
		record_t r[MAXN];
		int      nb, j, lst;
		logic    dup;
		nb = 0;
		dup = 0;
		for (int i = 0; i < m_count; i++)
			for (int k = i + 1; k < m_count; k++)
				if (m_addr[i] == m_addr[k]) dup = 1;
		if (m_ovf) begin
			add_rec(status_rec(REC_OVF));
			return;
		end
		if (dup) begin
			add_rec(status_rec(REC_DUP));
			return;
		end
		if (m_noimm) begin
			add_rec(status_rec(REC_NOIMM));
			return;
		end
		for (int i = 0; i < MAXN; i++) begin
			leader[i] = 0;
			reach[i] = 0;
		end
		leader[0] = 1;
		for (int i = 0; i < m_count; i++) begin
			if (m_kind[i] == KIND_JMP || m_kind[i] == KIND_CJMP) begin
				j = find_addr(m_tgt[i]);
				if (j >= 0) leader[j] = 1;
			end
			if (m_kind[i] != KIND_OTHER && i + 1 < m_count) leader[i + 1] = 1;
		end
		for (int i = 0; i < m_count; i++) begin
			if (leader[i]) begin
				if (nb > 0) bend[nb - 1] = i;
				bfirst[nb] = i;
				nb++;
			end
			owner[i] = nb - 1;
		end
		bend[nb - 1] = m_count;
		for (int b = 0; b < nb; b++) begin
			lst = bend[b] - 1;
			r[b] = '{kind: REC_BLOCK, be: EDGE_NONE, fe: EDGE_NONE, default: '0};
			r[b].baddr = m_addr[bfirst[b]];
			r[b].first = 5'(bfirst[b]);
			r[b].endi = 6'(bend[b]);
			if (m_kind[lst] != KIND_RET) begin
				if (m_kind[lst] != KIND_OTHER) begin
					r[b].ba = m_tgt[lst];
					j = find_addr(r[b].ba);
					r[b].be = (j >= 0) ? EDGE_RES : EDGE_UNRES;
					r[b].bb = (j >= 0) ? 5'(owner[j]) : 5'd0;
				end
				if (m_kind[lst] != KIND_JMP) begin
					r[b].fa = m_addr[lst] + 64'(m_len[lst]);
					j = find_addr(r[b].fa);
					r[b].fe = (j >= 0) ? EDGE_RES : EDGE_UNRES;
					r[b].fb = (j >= 0) ? 5'(owner[j]) : 5'd0;
				end
			end
		end
		reach[0] = 1;
		for (int it = 0; it < nb; it++)
			for (int b = 0; b < nb; b++)
				if (reach[b]) begin
					if (r[b].be == EDGE_RES) reach[r[b].bb] = 1;
					if (r[b].fe == EDGE_RES) reach[r[b].fb] = 1;
				end
		for (int b = 0; b < nb; b++) begin
			r[b].reach = reach[b];
			add_rec(r[b]);
		end
		add_rec(status_rec(REC_OK));
	endtask

	task automatic load_instr(instr_t it);
		if (m_count < MAXN) begin
			m_addr[m_count] = it.addr;
			m_len[m_count]  = it.len;
			m_kind[m_count] = it.kind;
			m_tgt[m_count]  = it.addr + 64'(it.len) + {{32{it.disp[31]}}, it.disp};
			m_count++;
			if ((it.kind == KIND_JMP || it.kind == KIND_CJMP) && !it.imm) m_noimm = 1;
		end else begin
			m_ovf = 1;
		end
		if (it.last) begin
			build_blocks();
			m_count = 0;
			m_noimm = 0;
			m_ovf = 0;
		end
	endtask

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("ERROR @%0d %s: got %h want %h", cycle, what, got, want);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle % 150 == 0) calm <= $urandom_range(0, 3) == 0;
		if (cycle > LIMIT) begin
			$display("basic_block_cfg_builder: mismatch");
			$finish;
		end
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			s_tlast  <= 0;
		end else begin
			if (s_tvalid && s_tready) load_instr(cur);
			if (!s_tvalid || s_tready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					s_tvalid <= 0;
				end else if (pending.size() > 0 && pending[0].drain) begin
					s_tvalid <= 0;
					if (expected_records.size() == 0 && !(s_tvalid && s_tready && cur.last))
						void'(pending.pop_front());
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					s_tdata  <= {3'b0, cur.disp, cur.imm, cur.len, cur.addr};
					s_tuser  <= cur.kind;
					s_tlast  <= cur.last;
					s_tvalid <= 1;
					tx_gap   <= pick_gap();
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (cycle == 3000) rx_hold <= 600;
			else if (rx_hold > 0) rx_hold <= rx_hold - 1;
			if (rx_gap > 0) rx_gap <= rx_gap - 1;
			else if (m_tready && m_tvalid) rx_gap <= pick_gap();
			m_tready <= (rx_hold == 0) && (rx_gap == 0);
		end
	end

	// monitor
	always @(posedge clk) begin
		record_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_records.size() == 0) begin
				report("unexpected word", 64'(m_tuser), 64'(0));
			end else begin
				w = expected_records.pop_front();
				if (m_tuser != w.kind) report("record_kind", 64'(m_tuser), 64'(w.kind));
				if (m_tdata[63:0] != w.baddr) report("block_address", m_tdata[63:0], w.baddr);
				if (m_tdata[68:64] != w.first)
					report("first_index", 64'(m_tdata[68:64]), 64'(w.first));
				if (m_tdata[74:69] != w.endi)
					report("end_index", 64'(m_tdata[74:69]), 64'(w.endi));
				if (m_tdata[75] != w.reach)
					report("reachable", 64'(m_tdata[75]), 64'(w.reach));
				if (m_tdata[77:76] != w.be)
					report("branch_edge", 64'(m_tdata[77:76]), 64'(w.be));
				if (m_tdata[141:78] != w.ba) report("branch_address", m_tdata[141:78], w.ba);
				if (m_tdata[146:142] != w.bb)
					report("branch_block", 64'(m_tdata[146:142]), 64'(w.bb));
				if (m_tdata[148:147] != w.fe)
					report("fallthrough_edge", 64'(m_tdata[148:147]), 64'(w.fe));
				if (m_tdata[212:149] != w.fa)
					report("fallthrough_address", m_tdata[212:149], w.fa);
				if (m_tdata[217:213] != w.fb)
					report("fallthrough_block", 64'(m_tdata[217:213]), 64'(w.fb));
				if (m_tdata[223:218] != 0) report("pad", 64'(m_tdata[223:218]), 64'(0));
				if (m_tlast != w.last) report("last_result", 64'(m_tlast), 64'(w.last));
			end
		end
	end

	task automatic push(logic [63:0] a, logic [3:0] l, ikind_t k, logic imm,
			logic [31:0] d, logic last);
		instr_t e;
		e = '{addr: a, len: l, kind: k, imm: imm, disp: d, last: last, drain: 0};
		pending.insert(pending.size(), e);
	endtask

	task automatic push_drain();
		instr_t e;
		e = '{addr: 0, len: 0, kind: KIND_OTHER, imm: 0, disp: 0, last: 0, drain: 1};
		pending.insert(pending.size(), e);
	endtask

	// list with consecutive addresses unless noise is set; jumps mostly land on list entries
	task automatic gen_run(int n, logic noise);
		logic [63:0] a[64];
		logic [3:0]  l[64];
		ikind_t      k;
		logic [31:0] d;
		logic        imm;
		int          r;
		for (int i = 0; i < n; i++) begin
			l[i] = ($urandom_range(0, 30) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
			a[i] = (i == 0) ? {$urandom, $urandom} : a[i - 1] + 64'(l[i - 1]);
		end
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 9);
			k = r < 5 ? KIND_OTHER : r < 7 ? KIND_CJMP : r < 9 ? KIND_JMP : KIND_RET;
			d = 32'(a[$urandom_range(0, n - 1)] - (a[i] + 64'(l[i])));
			if ($urandom_range(0, 7) == 0) d = $urandom;
			imm = $urandom_range(0, 40) != 0;
			if (noise)
				push({$urandom, $urandom}, 4'($urandom), ikind_t'($urandom_range(0, 3)),
					1'($urandom), $urandom, i == n - 1);
			else if ($urandom_range(0, 60) == 0 && i > 0)
				push(a[0], l[i], k, imm, d, i == n - 1);
			else
				push(a[i], l[i], k, imm, d, i == n - 1);
		end
	endtask

	initial begin
		int total;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		push(64'h0, 4'd1, KIND_OTHER, 0, 32'h0, 1);
		push(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, KIND_RET, 1, 32'h7FFF_FFFF, 1);
		push(64'h1000, 4'd2, KIND_JMP, 1, -32'sd2, 1);
		push(64'hFFFF_FFFF_FFFF_FFF8, 4'd4, KIND_OTHER, 0, 32'h8000_0000, 0);
		push(64'hFFFF_FFFF_FFFF_FFFC, 4'd4, KIND_CJMP, 1, -32'sd8, 0);
		push(64'h0, 4'd0, KIND_OTHER, 0, 32'h0, 0);
		push(64'h0, 4'd3, KIND_RET, 0, 32'hFFFF_FFFF, 1);
		push(64'h10, 4'd2, KIND_CJMP, 1, 32'h0, 0);
		push(64'h12, 4'd1, KIND_JMP, 1, 32'h8000_0000, 1);
		push(64'h20, 4'd2, KIND_OTHER, 1, 32'h0, 0);
		push(64'h20, 4'd2, KIND_OTHER, 1, 32'h0, 1);
		push(64'h30, 4'd2, KIND_JMP, 0, 32'h0, 1);
		push(64'h40, 4'd2, KIND_CJMP, 0, 32'h0, 0);
		push(64'h40, 4'd2, KIND_OTHER, 1, 32'h0, 1);
		push_drain();
		gen_run(MAXN, 0);
		gen_run(MAXN + 3, 0);
		push_drain();
		total = 0;
		while (total < 460) begin
			int n;
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 10);
			gen_run(n, $urandom_range(0, 9) == 0);
			total += n;
			if ($urandom_range(0, 15) == 0) push_drain();
		end

		wait (pending.size() == 0 && !s_tvalid);
		wait (expected_records.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("basic_block_cfg_builder: match");
		else
			$display("basic_block_cfg_builder: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
